[hdl/tcl_pkg.sv]
package tcl_pkg;

    localparam int ACC_W      = 48;   // accumulator, signed Q.24
    localparam int HALF_W     = 24;   // accumulator split for the two partial products
    localparam int X_W        = 16;   // x, unsigned Q0.16
    localparam int COEF_FRAC  = 24;
    localparam int OFFSET_W   = 7;
    localparam int TEMP_W     = 16;
    localparam int DISP_W     = 8;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [IDX_W-1:0] DEG_J = 4'd5;
    localparam logic [IDX_W-1:0] DEG_K = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_TYPE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'b1;

    localparam logic [DISP_W-1:0] DISPLAY_FULL = 8'hFF;
    localparam int                OVER_LIMIT   = 254;

    typedef struct packed {
        logic             load;
        logic             mul;
        logic             add;
        logic             fin;
        logic             emit;
        logic             type_k;
        logic [IDX_W-1:0] coef_idx;
    } t_dp_cmd;

    // Horner coefficients a_i * (5/101)^i in Q.24, x = fraction of full scale
    function automatic logic signed [ACC_W-1:0] coef(input logic type_k,
                                                     input logic [IDX_W-1:0] idx);
        logic signed [ACC_W-1:0] c;
        c = '0;
        if (type_k) begin
            case (idx)
                4'd0:    c =  48'sd3801459;
                4'd1:    c =  48'sd20059660862;
                4'd2:    c =  48'sd2764409596;
                4'd3:    c =  48'sd4499093368;
                4'd4:    c = -48'sd86756019546;
                4'd5:    c =  48'sd241193120590;
                4'd6:    c = -48'sd292518998073;
                4'd7:    c =  48'sd169552992021;
                4'd8:    c = -48'sd38352893111;
                default: c = '0;
            endcase
        end else begin
            case (idx)
                4'd0:    c = -48'sd819873;
                4'd1:    c =  48'sd16505744891;
                4'd2:    c = -48'sd8988685563;
                4'd3:    c =  48'sd23548817803;
                4'd4:    c = -48'sd26694704347;
                4'd5:    c =  48'sd10068833868;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

[hdl/tcl_ctrl.sv]
module tcl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_type_k,
    output logic             busy,
    output tcl_pkg::t_dp_cmd o_cmd
);
    import tcl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_type_k, n_type_k;
    logic [IDX_W-1:0] w_deg;

    assign w_deg = i_type_k ? DEG_K : DEG_J;
    assign busy  = (r_state != S_IDLE);

    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        n_type_k        = r_type_k;
        o_cmd           = '0;
        o_cmd.type_k    = r_type_k;
        o_cmd.coef_idx  = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    // accumulator starts at the leading coefficient
                    o_cmd.load     = 1'b1;
                    o_cmd.type_k   = i_type_k;
                    o_cmd.coef_idx = w_deg;
                    n_type_k       = i_type_k;
                    n_idx          = w_deg - 1'b1;
                    n_state        = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_idx == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_type_k <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_type_k <= n_type_k;
        end
    end

endmodule

[hdl/tcl_dp.sv]
module tcl_dp #(
    parameter int ADC_BITS       = 10,
    parameter int TEMP_FRAC_BITS = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  tcl_pkg::t_dp_cmd                        i_cmd,
    input  logic [ADC_BITS-1:0]                     i_adc_code,
    input  logic [tcl_pkg::OFFSET_W-1:0]            i_offset,
    output logic                                    o_result_valid,
    output logic signed [tcl_pkg::TEMP_W-1:0]       o_temperature_sixteenths,
    output logic [tcl_pkg::DISP_W-1:0]              o_display_byte,
    output logic                                    o_over_range
);
    import tcl_pkg::*;

    localparam int PROD_LO_W = HALF_W + X_W;
    localparam int PROD_HI_W = HALF_W + X_W + 1;
    localparam int FULL_W    = 2 * ACC_W - X_W;
    localparam int T_SHIFT   = COEF_FRAC - TEMP_FRAC_BITS;
    localparam int DEG_W     = ACC_W - COEF_FRAC;

    logic        [X_W-1:0]       r_x;
    logic signed [ACC_W-1:0]     r_acc;
    logic        [PROD_LO_W-1:0] r_prod_lo;
    logic signed [PROD_HI_W-1:0] r_prod_hi;

    logic signed [ACC_W-1:0]     w_coef;
    logic signed [FULL_W-1:0]    w_full;
    logic signed [ACC_W-1:0]     w_step;
    logic signed [ACC_W-1:0]     w_t;
    logic signed [DEG_W-1:0]     w_deg;

    logic                        r_valid;
    logic signed [TEMP_W-1:0]    r_temp,  n_temp;
    logic        [DISP_W-1:0]    r_disp,  n_disp;
    logic                        r_over,  n_over;

    assign w_coef = coef(i_cmd.type_k, i_cmd.coef_idx);

    // product = hi * 2^24 + lo; dropping 16 low bits of the exact sum is floor
    assign w_full = ($signed({{(FULL_W-PROD_HI_W){r_prod_hi[PROD_HI_W-1]}}, r_prod_hi})
                     <<< HALF_W)
                  + $signed({{(FULL_W-PROD_LO_W){1'b0}}, r_prod_lo});
    assign w_step = $signed(w_full[X_W +: ACC_W]) + w_coef;

    assign w_t   = r_acc >>> T_SHIFT;
    assign w_deg = r_acc[ACC_W-1 -: DEG_W];

    always_comb begin
        if (w_t > ACC_W'(32767)) begin
            n_temp = 16'sh7FFF;
        end else if (w_t < -ACC_W'(32768)) begin
            n_temp = 16'sh8000;
        end else begin
            n_temp = w_t[TEMP_W-1:0];
        end
        if (w_deg >= DEG_W'(OVER_LIMIT)) begin
            n_disp = DISPLAY_FULL;
            n_over = 1'b1;
        end else if (w_deg[DEG_W-1]) begin
            n_disp = '0;
            n_over = 1'b0;
        end else begin
            n_disp = w_deg[DISP_W-1:0];
            n_over = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= X_W'(i_adc_code) << (X_W - ADC_BITS);
            r_acc <= w_coef;
        end
        if (i_cmd.mul) begin
            r_prod_lo <= r_acc[HALF_W-1:0] * r_x;
            r_prod_hi <= $signed(r_acc[ACC_W-1:HALF_W]) * $signed({1'b0, r_x});
        end
        if (i_cmd.add) begin
            r_acc <= w_step;
        end
        if (i_cmd.fin) begin
            r_acc <= r_acc + $signed(ACC_W'(i_offset) << COEF_FRAC);
        end
        if (i_cmd.emit) begin
            r_temp <= n_temp;
            r_disp <= n_disp;
            r_over <= n_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_result_valid           = r_valid;
    assign o_temperature_sixteenths = r_temp;
    assign o_display_byte           = r_disp;
    assign o_over_range             = r_over;

endmodule

[hdl/thermocouple_linearizer_core.sv]
// Channel   Direction  Ports                                  Handshake
// request   in         i_adc_code                             start high, busy low
// result    out        o_temperature_sixteenths,              o_result_valid, one cycle
//                      o_display_byte, o_over_range
// config    in         i_cfg_index, i_cfg_data                i_cfg_we, no wait
//
// One Horner step runs on a pair of multipliers (24x16 unsigned low half, 24x17 signed
// high half): multiply, then combine and add the coefficient; offset add and output follow.
// Busy is high while a conversion runs and drops in the result strobe cycle, so a new
// request is accepted only once the previous result is out.
// Synchronous active-low reset; the receiver cannot stall, results are never held.
module thermocouple_linearizer_core #(
    parameter int ADC_BITS       = 10,
    parameter int TEMP_FRAC_BITS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ADC_BITS-1:0]                  i_adc_code,
    input  logic                                 i_cfg_we,
    input  logic [tcl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tcl_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_result_valid,
    output logic signed [tcl_pkg::TEMP_W-1:0]    o_temperature_sixteenths,
    output logic [tcl_pkg::DISP_W-1:0]           o_display_byte,
    output logic                                 o_over_range
);
    import tcl_pkg::*;

    logic                r_type_k;
    logic [OFFSET_W-1:0] r_offset;
    t_dp_cmd             w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_k <= 1'b0;
            r_offset <= 7'd15;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TYPE:   r_type_k <= i_cfg_data[0];
                REG_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                default:    ;
            endcase
        end
    end

    tcl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_type_k (r_type_k),
        .busy     (busy),
        .o_cmd    (w_cmd)
    );

    tcl_dp #(
        .ADC_BITS       (ADC_BITS),
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
    ) u_dp (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (w_cmd),
        .i_adc_code               (i_adc_code),
        .i_offset                 (r_offset),
        .o_result_valid           (o_result_valid),
        .o_temperature_sixteenths (o_temperature_sixteenths),
        .o_display_byte           (o_display_byte),
        .o_over_range             (o_over_range)
    );

endmodule
